// ===== sv/pp_pkg.sv =====
// Package for the polygon perimeter core: item structs, field widths and
// the sequencer state type. No dependencies.
package pp_pkg;

  // Fixed field widths of the input and result items
  localparam int FIELD_W = 16;
  localparam int SUM_W = 48;
  // Radicand is kept modulo 2^64
  localparam int RAD_MAX_W = 64;

  typedef struct packed {
    logic signed [FIELD_W-1:0] x;
    logic signed [FIELD_W-1:0] y;
    logic                      last_point;
  } in_item_t;

  typedef struct packed {
    logic [SUM_W-1:0] perimeter;
    logic             saturated;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_SQX,
    ST_SQY,
    ST_ROOT,
    ST_ACC,
    ST_OUT
  } pp_state_e;

endpackage

// ===== sv/polygon_perimeter_core.sv =====
// Closed polygon perimeter: vertices in, one perimeter item per polygon out.
// Depends on pp_pkg (item structs, widths, state type).
//
//   channel | signals                           | carries
//   in      | in_valid_i, in_ready_o, in_item_i  | one vertex (x, y, last_point)
//   out     | out_valid_o, out_ready_i, out_item_o | perimeter, saturated
//
// Each edge length runs through the operand differences, the squaring of x
// and of y, the serial square root at one root bit per cycle, and the
// accumulate step. The root loop sets the rate.
// A first vertex that is not last is taken without edge work, a single vertex
// marked last runs one zero-length edge and the output load, a later vertex
// runs one edge, and a later vertex marked last also the closing edge and the output load.
// Reset clears the sequencer, the polygon flags, the running sum and the
// output valid flag.
// A waiting result does not block the next vertex; only loading a new
// result stalls until the output register is free.
module polygon_perimeter_core #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pp_pkg::in_item_t  in_item_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output pp_pkg::out_item_t out_item_o
);
  import pp_pkg::*;

  localparam int EXT_W    = (COORD_BITS > FIELD_W) ? COORD_BITS : FIELD_W;
  localparam int DIFF_W   = COORD_BITS + 1;
  localparam int SQ_W     = 2 * COORD_BITS + 1;
  localparam int RAD_FULL = SQ_W + 2 * FRAC_BITS;
  localparam int RAD_W    = (RAD_FULL > RAD_MAX_W) ? RAD_MAX_W : RAD_FULL;
  localparam int RAD_EVEN = RAD_W + (RAD_W % 2);
  localparam int ROOT_W   = RAD_EVEN / 2;
  localparam int REM_W    = ROOT_W + 2;
  localparam int CNT_W    = $clog2(ROOT_W);

  // Take the low COORD_BITS bits of a field as a signed coordinate
  function automatic logic signed [COORD_BITS-1:0] to_coord(logic [FIELD_W-1:0] raw);
    logic [EXT_W-1:0] w;
    w = EXT_W'(raw);
    return signed'(w[COORD_BITS-1:0]);
  endfunction

  pp_state_e state_q, state_d;

  logic                         have_q, last_q, pend_close_q;
  logic [CNT_W-1:0]             cnt_q;
  logic [SUM_W-1:0]             sum_q;
  logic                         clip_q;
  logic                         out_valid_q;
  out_item_t                    out_q;

  logic signed [COORD_BITS-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
  logic signed [COORD_BITS-1:0] ea_x_q, ea_y_q, eb_x_q, eb_y_q;
  logic [COORD_BITS-1:0]        ux_q, uy_q;
  logic [2*COORD_BITS-1:0]      sq_q;
  logic [RAD_EVEN-1:0]          rad_q;
  logic [REM_W-1:0]             rem_q;
  logic [ROOT_W-1:0]            root_q;

  logic signed [COORD_BITS-1:0] px, py;
  logic                         in_acc, out_load;
  logic signed [DIFF_W-1:0]     dx, dy, ndx, ndy;
  logic [COORD_BITS-1:0]        ux_d, uy_d;
  logic [2*COORD_BITS-1:0]      sqy;
  logic [SQ_W-1:0]              sq_sum;
  logic [RAD_FULL-1:0]          rad_full;
  logic [RAD_EVEN-1:0]          rad_init;
  logic [REM_W-1:0]             rem_sh, trial, rem_d;
  logic [ROOT_W-1:0]            root_d;
  logic [SUM_W:0]               sum_ext;

  assign px = to_coord(in_item_i.x);
  assign py = to_coord(in_item_i.y);

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_load    = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Edge vector magnitudes
  always_comb begin
    dx   = DIFF_W'(eb_x_q) - DIFF_W'(ea_x_q);
    dy   = DIFF_W'(eb_y_q) - DIFF_W'(ea_y_q);
    ndx  = -dx;
    ndy  = -dy;
    ux_d = dx[DIFF_W-1] ? ndx[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
    uy_d = dy[DIFF_W-1] ? ndy[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
  end

  // Radicand: sum of squares, scaled by the fraction bits, kept to at most 64 bits
  always_comb begin
    sqy      = uy_q * uy_q;
    sq_sum   = SQ_W'(sq_q) + SQ_W'(sqy);
    rad_full = RAD_FULL'(sq_sum) << (2 * FRAC_BITS);
    rad_init = RAD_EVEN'(rad_full[RAD_W-1:0]);
  end

  // One root bit per cycle: bring in two radicand bits, try 4q+1
  always_comb begin
    rem_sh = {rem_q[ROOT_W-1:0], rad_q[RAD_EVEN-1 -: 2]};
    trial  = {root_q, 2'b01};
    if (rem_sh >= trial) begin
      rem_d  = rem_sh - trial;
      root_d = {root_q[ROOT_W-2:0], 1'b1};
    end else begin
      rem_d  = rem_sh;
      root_d = {root_q[ROOT_W-2:0], 1'b0};
    end
  end

  // Saturating add of the finished edge length
  assign sum_ext = {1'b0, sum_q} + (SUM_W+1)'(root_q);

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && (have_q || in_item_i.last_point)) state_d = ST_DIFF;
      end
      ST_DIFF: state_d = ST_SQX;
      ST_SQX:  state_d = ST_SQY;
      ST_SQY:  state_d = ST_ROOT;
      ST_ROOT: begin
        if (cnt_q == '0) state_d = ST_ACC;
      end
      ST_ACC: begin
        priority if (pend_close_q) state_d = ST_DIFF;
        else if (last_q)           state_d = ST_OUT;
        else                       state_d = ST_IDLE;
      end
      ST_OUT: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Control state: polygon flags, running sum, root counter, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q       <= 1'b0;
      last_q       <= 1'b0;
      pend_close_q <= 1'b0;
      cnt_q        <= '0;
      sum_q        <= '0;
      clip_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (in_acc) begin
        last_q <= in_item_i.last_point;
        if (have_q) begin
          pend_close_q <= in_item_i.last_point;
        end else begin
          have_q       <= 1'b1;
          sum_q        <= '0;
          clip_q       <= 1'b0;
          pend_close_q <= 1'b0;
        end
      end
      if (state_q == ST_SQY) cnt_q <= CNT_W'(ROOT_W - 1);
      if (state_q == ST_ROOT) cnt_q <= cnt_q - 1'b1;
      if (state_q == ST_ACC) begin
        if (sum_ext[SUM_W]) begin
          sum_q  <= '1;
          clip_q <= 1'b1;
        end else begin
          sum_q <= sum_ext[SUM_W-1:0];
        end
        pend_close_q <= 1'b0;
      end
      // Deliver the perimeter and start a fresh polygon
      if (out_load) begin
        have_q <= 1'b0;
        sum_q  <= '0;
        clip_q <= 1'b0;
      end
      if (out_load)         out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      prev_x_q <= px;
      prev_y_q <= py;
      eb_x_q   <= px;
      eb_y_q   <= py;
      if (have_q) begin
        ea_x_q <= prev_x_q;
        ea_y_q <= prev_y_q;
      end else begin
        first_x_q <= px;
        first_y_q <= py;
        ea_x_q    <= px;
        ea_y_q    <= py;
      end
    end
    unique case (state_q)
      ST_DIFF: begin
        ux_q <= ux_d;
        uy_q <= uy_d;
      end
      ST_SQX: sq_q <= ux_q * ux_q;
      ST_SQY: begin
        rad_q  <= rad_init;
        rem_q  <= '0;
        root_q <= '0;
      end
      ST_ROOT: begin
        rad_q  <= rad_q << 2;
        rem_q  <= rem_d;
        root_q <= root_d;
      end
      ST_ACC: begin
        // Set up the closing edge back to the first vertex
        if (pend_close_q) begin
          ea_x_q <= eb_x_q;
          ea_y_q <= eb_y_q;
          eb_x_q <= first_x_q;
          eb_y_q <= first_y_q;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          out_q.perimeter <= sum_q;
          out_q.saturated <= clip_q;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== sv/pp_checker.sv =====
// Port-level checks for polygon_perimeter_core, bound into that module.
// Depends on pp_pkg for the item structs.
module pp_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input pp_pkg::in_item_t  in_item_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input pp_pkg::out_item_t out_item_o
);
  import pp_pkg::*;

  logic       in_acc, out_acc;
  logic       have_q, have_d;
  logic [1:0] pend_q, pend_d;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  // Track open polygons and perimeters owed
  always_comb begin
    have_d = have_q;
    pend_d = pend_q;
    if (in_acc) have_d = !in_item_i.last_point;
    if (in_acc && in_item_i.last_point && !out_acc) pend_d = pend_q + 2'd1;
    else if (out_acc && !(in_acc && in_item_i.last_point)) pend_d = pend_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
      pend_q <= '0;
    end else begin
      have_q <= have_d;
      pend_q <= pend_d;
    end
  end

  // A waiting result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  // A clipped sum is reported at its maximum
  a_sat_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.saturated |-> (&out_item_o.perimeter))
    else $error("saturated result below maximum");

  // A vertex that closes an edge keeps the block busy
  a_edge_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && have_q |=> !in_ready_o)
    else $error("ready during edge computation");

  // No result without a finished polygon
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != 2'd0)
    else $error("result without a last vertex");

  // At most one polygon waits behind a full output register
  a_backlog: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q == 2'd2 |-> !in_ready_o)
    else $error("vertex taken with two perimeters owed");

endmodule

bind polygon_perimeter_core pp_checker u_pp_checker (.*);
